### sv/jacf_pkg.sv
// Shared types and constants for the joystick axis conditioner and framer.
package jacf_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int DZ_W      = 8;
    localparam int BUTTON_W  = 4;
    localparam int CODE_W    = 5;
    localparam int VAL_W     = 9;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE     = 1'b1;

    localparam logic [SAMPLE_W-1:0] CENTER_RESET    = 12'd1900;
    localparam logic [DZ_W-1:0]     DEAD_ZONE_RESET = 8'd50;

    localparam logic [CODE_W-1:0]   CODE_BUTTON_BASE = 5'd11;
    localparam logic [BUTTON_W-1:0] BUTTON_COUNT     = 4'd11;
    localparam logic [7:0]          FRAME_END        = 8'hFF;

    // conditioned item, one per transaction that produces a packet
    typedef struct packed {
        logic                     is_btn;
        logic                     axis;
        logic [CODE_W-1:0]        code;
        logic signed [VAL_W-1:0]  value;
    } t_cond_item;

endpackage

### sv/jacf_cond.sv
// Sample conditioning: center, divide by 12, saturate, dead zone; button code mapping.
module jacf_cond (
    input  logic                           i_op,
    input  logic                           i_axis,
    input  logic [jacf_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [jacf_pkg::BUTTON_W-1:0]  i_button,
    input  logic                           i_pressed,
    input  logic [jacf_pkg::SAMPLE_W-1:0]  i_center,
    input  logic [jacf_pkg::DZ_W-1:0]      i_dead_zone,
    output logic                           o_keep,
    output jacf_pkg::t_cond_item           o_item
);
    import jacf_pkg::*;

    // x/3 == (x*683)>>11 exactly for x < 2048
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    logic signed [SAMPLE_W:0]  centered;
    logic                      neg;
    logic [SAMPLE_W:0]         centered_neg;
    logic [SAMPLE_W-1:0]       mag;
    logic [19:0]               prod;
    logic [VAL_W-1:0]          quot;
    logic [VAL_W-1:0]          sat;
    logic signed [VAL_W-1:0]   scaled;

    always_comb begin
        centered     = $signed({1'b0, i_sample}) - $signed({1'b0, i_center});
        neg          = centered[SAMPLE_W];
        centered_neg = -centered;
        mag          = neg ? centered_neg[SAMPLE_W-1:0] : centered[SAMPLE_W-1:0];
        // divide by 12 = drop two bits, then divide by 3
        prod = 20'(mag[SAMPLE_W-1:2]) * 20'(DIV3_MUL);
        quot = prod[DIV3_SHIFT +: VAL_W];
        if (neg) begin
            sat = (quot > 9'd256) ? 9'd256 : quot;
        end else begin
            sat = (quot > 9'd255) ? 9'd255 : quot;
        end
        if (sat <= {1'b0, i_dead_zone}) begin
            scaled = '0;
        end else if (neg) begin
            scaled = -$signed(sat);
        end else begin
            scaled = $signed(sat);
        end
    end

    always_comb begin
        o_item.is_btn = i_op;
        o_item.axis   = i_axis;
        if (i_op) begin
            o_item.code  = CODE_BUTTON_BASE + CODE_W'(i_button);
            o_item.value = $signed({{(VAL_W-1){1'b0}}, i_pressed});
            o_keep       = (i_button < BUTTON_COUNT);
        end else begin
            o_item.code  = CODE_W'(i_axis);
            o_item.value = scaled;
            o_keep       = 1'b1;
        end
    end

endmodule

### sv/jacf_window.sv
// Per-axis ring of conditioned values with a running sum.
module jacf_window #(
    parameter int WINDOW_LEN = 5,
    parameter int SUM_W      = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_axis,
    input  logic signed [jacf_pkg::VAL_W-1:0] i_value,
    output logic signed [SUM_W-1:0]           o_sum
);
    import jacf_pkg::*;

    localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

    logic signed [VAL_W-1:0] r_store [2][WINDOW_LEN];
    logic signed [SUM_W-1:0] r_sum   [2];
    logic [POS_W-1:0]        r_pos   [2];

    logic [POS_W-1:0]        cur_pos;
    logic signed [VAL_W-1:0] old_val;
    logic [POS_W-1:0]        n_pos;

    always_comb begin
        cur_pos = r_pos[i_axis];
        old_val = r_store[i_axis][cur_pos];
        o_sum   = r_sum[i_axis] - SUM_W'(old_val) + SUM_W'(i_value);
        n_pos   = (cur_pos == POS_LAST) ? '0 : cur_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 2; a++) begin
                r_sum[a] <= '0;
                r_pos[a] <= '0;
                for (int i = 0; i < WINDOW_LEN; i++) begin
                    r_store[a][i] <= '0;
                end
            end
        end else if (i_en) begin
            r_store[i_axis][cur_pos] <= i_value;
            r_sum[i_axis]            <= o_sum;
            r_pos[i_axis]            <= n_pos;
        end
    end

endmodule

### sv/jacf_framer.sv
// Window average (divide by constant) into the result register, then four-byte packet output.
module jacf_framer #(
    parameter int WINDOW_LEN = 5,
    parameter int SUM_W      = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [jacf_pkg::CODE_W-1:0]      i_code,
    input  logic                             i_is_btn,
    input  logic signed [SUM_W-1:0]          i_sum,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,
    output logic                             m_axis_tlast
);
    import jacf_pkg::*;

    // reciprocal multiply: exact floor(x/WINDOW_LEN) for x < 2**SUM_W
    localparam int L_BITS  = $clog2(WINDOW_LEN);
    localparam int SHIFT   = SUM_W + L_BITS;
    localparam int RECIP   = ((1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;

    localparam logic [1:0] BEAT_CODE = 2'd0;
    localparam logic [1:0] BEAT_LOW  = 2'd1;
    localparam logic [1:0] BEAT_HIGH = 2'd2;
    localparam logic [1:0] BEAT_END  = 2'd3;

    logic [RECIP_W-1:0]      recip;
    logic                    neg;
    logic [SUM_W-1:0]        sum_neg;
    logic [SUM_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [VAL_W-1:0]        quot;
    logic signed [VAL_W-1:0] n_value;

    logic                    r_valid;
    logic [1:0]              r_beat;
    logic [CODE_W-1:0]       r_code;
    logic signed [VAL_W-1:0] r_value;

    always_comb begin
        recip   = RECIP_W'(RECIP);
        neg     = i_sum[SUM_W-1];
        sum_neg = -i_sum;
        mag     = neg ? sum_neg : i_sum;
        prod    = PROD_W'(mag) * PROD_W'(recip);
        quot    = prod[SHIFT +: VAL_W];
        if (i_is_btn) begin
            n_value = i_sum[VAL_W-1:0];
        end else if (neg) begin
            n_value = -$signed(quot);
        end else begin
            n_value = $signed(quot);
        end
    end

    assign o_ready = !r_valid || (m_axis_tready && r_beat == BEAT_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_CODE;
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_beat  <= BEAT_CODE;
        end else if (m_axis_tready) begin
            r_beat  <= r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_code  <= i_code;
            r_value <= n_value;
        end
    end

    always_comb begin
        case (r_beat)
            BEAT_CODE: m_axis_tdata = 8'(r_code);
            BEAT_LOW:  m_axis_tdata = r_value[7:0];
            BEAT_HIGH: m_axis_tdata = {8{r_value[VAL_W-1]}};
            BEAT_END:  m_axis_tdata = FRAME_END;
            default:   m_axis_tdata = FRAME_END;
        endcase
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = (r_beat == BEAT_END);

endmodule

### sv/joystick_axis_conditioner_framer_unit.sv
// Top level: joystick axis conditioner and packet framer.
// Each input transaction is either a joystick sample (tuser = 0) or a button edge
// (tuser = 1). A sample is centered by center_offset, divided by 12 toward zero,
// saturated to -256..255, zeroed inside +/-dead_zone_half, pushed into its axis's
// ring of WINDOW_LEN entries, and reported as the ring sum divided by WINDOW_LEN
// (toward zero). A button edge reports code 11+index with value 1 on press, 0 on
// release; indexes above 10 are dropped and give no output. Every reported item
// is a four-byte packet on the master side: code, value low byte, value high byte
// (sign fill), 0xFF with tlast. The item rate is set by the byte-wide master
// port; the slave side keeps accepting while a packet drains, until the input,
// conditioning and window sum registers are full. From input acceptance to the
// code byte, an item passes the input register, conditioning register, window
// sum register, then the result register that the packet is read from. Config
// writes (index 0 center_offset, index 1 dead_zone_half) are registered and are
// expected only while idle. Windows are cleared by reset.
module joystick_axis_conditioner_framer_unit #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [jacf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [jacf_pkg::CFG_W-1:0]       i_cfg_data,
    // slave side
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [0] axis, [12:1] sample, [16:13] button, [17] pressed, [23:18] zero
    input  logic [23:0]                      s_axis_tdata,
    // tuser: [0] op (0 sample, 1 button edge)
    input  logic                             s_axis_tuser,
    // master side
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: [7:0] frame_byte
    output logic [7:0]                       m_axis_tdata,
    output logic                             m_axis_tlast
);
    import jacf_pkg::*;

    localparam int SUM_W = VAL_W + $clog2(WINDOW_LEN);

    // config registers
    logic [SAMPLE_W-1:0]  r_center;
    logic [DZ_W-1:0]      r_dead_zone;

    // stage A: input register
    logic                 r_a_valid;
    logic                 r_a_op;
    logic                 r_a_axis;
    logic [SAMPLE_W-1:0]  r_a_sample;
    logic [BUTTON_W-1:0]  r_a_button;
    logic                 r_a_pressed;

    // stage B: conditioned item
    logic                 r_b_valid;
    t_cond_item           r_b_item;

    // stage C: window sum
    logic                 r_c_valid;
    logic [CODE_W-1:0]    r_c_code;
    logic                 r_c_is_btn;
    logic signed [SUM_W-1:0] r_c_sum;

    logic                 a_ready;
    logic                 b_ready;
    logic                 c_ready;
    logic                 cond_keep;
    t_cond_item           cond_item;
    logic                 win_en;
    logic signed [SUM_W-1:0] win_sum;
    logic signed [SUM_W-1:0] n_c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center    <= CENTER_RESET;
            r_dead_zone <= DEAD_ZONE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CENTER_OFFSET: r_center    <= i_cfg_data;
                REG_DEAD_ZONE:     r_dead_zone <= i_cfg_data[DZ_W-1:0];
                default:           ;
            endcase
        end
    end

    // ready chain, back from the result register
    assign b_ready       = !r_b_valid || c_ready;
    assign a_ready       = !r_a_valid || b_ready;
    assign s_axis_tready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= s_axis_tvalid;
            end
            if (b_ready) begin
                // out-of-range button edges vanish here
                r_b_valid <= r_a_valid && cond_keep;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && s_axis_tvalid) begin
            r_a_op      <= s_axis_tuser;
            r_a_axis    <= s_axis_tdata[0];
            r_a_sample  <= s_axis_tdata[12:1];
            r_a_button  <= s_axis_tdata[16:13];
            r_a_pressed <= s_axis_tdata[17];
        end
        if (b_ready && r_a_valid) begin
            r_b_item <= cond_item;
        end
        if (c_ready && r_b_valid) begin
            r_c_code   <= r_b_item.code;
            r_c_is_btn <= r_b_item.is_btn;
            r_c_sum    <= n_c_sum;
        end
    end

    jacf_cond u_cond (
        .i_op        (r_a_op),
        .i_axis      (r_a_axis),
        .i_sample    (r_a_sample),
        .i_button    (r_a_button),
        .i_pressed   (r_a_pressed),
        .i_center    (r_center),
        .i_dead_zone (r_dead_zone),
        .o_keep      (cond_keep),
        .o_item      (cond_item)
    );

    // ring update happens as a sample moves from B to C
    assign win_en = r_b_valid && c_ready && !r_b_item.is_btn;

    jacf_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (win_en),
        .i_axis  (r_b_item.axis),
        .i_value (r_b_item.value),
        .o_sum   (win_sum)
    );

    // button value rides in the sum field and bypasses the divide
    assign n_c_sum = r_b_item.is_btn ? SUM_W'(r_b_item.value) : win_sum;

    jacf_framer #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_c_valid),
        .o_ready       (c_ready),
        .i_code        (r_c_code),
        .i_is_btn      (r_c_is_btn),
        .i_sum         (r_c_sum),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // closing byte of every packet is the frame marker
    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == FRAME_END))
        else $error("packet end byte is not the frame marker");

    // a packet never breaks off before its last byte
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("packet interrupted before tlast");

    // stalled window sum stage holds its result
    a_c_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !c_ready) |=> (r_c_valid && $stable(r_c_sum)))
        else $error("sum stage lost or changed a stalled item");

    // out-of-range button never reaches the conditioned stage
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && b_ready && r_a_op && (r_a_button >= BUTTON_COUNT)) |=> !r_b_valid)
        else $error("invalid button index passed conditioning");

endmodule
